// ===== design/binary_min_heap_priority_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// Binary min-heap priority queue: assertion macros
// Shared assertion forms for checkers clocked by i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// checked outside reset only
`define BMHPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bmhpq: property failed");

// checked in and out of reset
`define BMHPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bmhpq: property failed");

`endif

// ===== design/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 11;
    localparam int CAP_RESET   = 1024;
    localparam int COST_W      = 32;
    localparam int PAY_W       = 32;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_BUILD  = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_PEEK   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic        [PAY_W-1:0]  payload;
    } t_entry;

    typedef struct packed {
        logic        [2:0]        opcode;
        logic signed [COST_W-1:0] item_cost;
        logic        [PAY_W-1:0]  item_payload;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [COST_W-1:0] top_cost;
        logic        [PAY_W-1:0]  top_payload;
        logic        [CNT_W-1:0]  count;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_entry a;
        t_entry b;
    } t_cmp_req;

    typedef struct packed {
        logic   a_gt_b;
        t_entry lesser;
    } t_cmp_rsp;

endpackage

// ===== design/binary_min_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top
// Binary min-heap of signed-cost entries with load, build, insert,
// delete-min and peek, one result beat per command.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  command   start, busy                i_item   (t_in_item)
//  result    o_done (one-cycle strobe)  o_result (t_out_item)
//  config    i_cfg_valid, o_cfg_ready   i_cfg_data (capacity)
//
//  Load, peek, spare opcodes, full/empty cases: the top read, then the result.
//  Insert: a parent read and compare per level climbed; stops at the root or on a compare.
//  Delete-min: reads the last entry, then sinks it from the root with the
//  child reads and compares per level. Build: sinks each interior node in
//  turn, last first. One read port and one shared comparator serialize the steps.
//  Reset clears control state only; the entry store is not cleared.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bmhpq_pkg::t_in_item        i_item,
    output logic                       o_done,
    output bmhpq_pkg::t_out_item       o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bmhpq_pkg::CAP_W-1:0] i_cfg_data
);
    import bmhpq_pkg::*;

    t_ram_req w_ram_req;
    t_entry   w_ram_rdata;
    t_cmp_req w_cmp_req;
    t_cmp_rsp w_cmp_rsp;

    assign o_cfg_ready = 1'b1;

    bmhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata),
        .o_cmp_req   (w_cmp_req),
        .i_cmp_rsp   (w_cmp_rsp)
    );

    bmhpq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    bmhpq_cmp u_cmp (
        .i_req (w_cmp_req),
        .o_rsp (w_cmp_rsp)
    );

endmodule

// ===== design/bmhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ram
// Heap entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmhpq_ram (
    input  logic                i_clk,
    input  bmhpq_pkg::t_ram_req i_req,
    output bmhpq_pkg::t_entry   o_rdata
);
    import bmhpq_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bmhpq_cmp.sv =====
// ----------------------------------------------------------------------------
// bmhpq_cmp
// Shared cost comparator: signed a > b and the lesser entry (a on a tie).
// ----------------------------------------------------------------------------
module bmhpq_cmp (
    input  bmhpq_pkg::t_cmp_req i_req,
    output bmhpq_pkg::t_cmp_rsp o_rsp
);
    import bmhpq_pkg::*;

    logic w_gt;

    assign w_gt          = i_req.a.cost > i_req.b.cost;
    assign o_rsp.a_gt_b  = w_gt;
    assign o_rsp.lesser  = w_gt ? i_req.b : i_req.a;

endmodule

// ===== design/bmhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Operation sequencer: load, build, insert, delete-min and peek over the
// entry store, one memory access and one cost compare per step.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  bmhpq_pkg::t_in_item       i_item,
    output logic                      o_busy,
    output logic                      o_done,
    output bmhpq_pkg::t_out_item      o_result,
    input  logic                      i_cfg_we,
    input  logic [bmhpq_pkg::CAP_W-1:0] i_cfg_data,
    output bmhpq_pkg::t_ram_req       o_ram_req,
    input  bmhpq_pkg::t_entry         i_ram_rdata,
    output bmhpq_pkg::t_cmp_req       o_cmp_req,
    input  bmhpq_pkg::t_cmp_rsp       i_cmp_rsp
);
    import bmhpq_pkg::*;

    localparam int WIDE_W = ADDR_W + 2;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SU_CHK, S_SU_CMP, S_BD_RD, S_BD_LAT, S_DL_RD, S_DL_LAT,
        S_SD_CHK, S_SD_L, S_SD_R, S_SD_DEC, S_SD_END, S_TOP_RD, S_TOP_LAT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CAP_W-1:0]  r_cap;
    logic              r_done;
    t_out_item         r_result;
    t_status           r_status;
    logic              r_build;
    logic [CNT_W-1:0]  r_n;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_j;
    logic [ADDR_W-1:0] r_cidx;
    t_entry            r_x;
    t_entry            r_left;
    t_entry            r_chosen;

    logic              w_accept;
    logic              w_full;
    t_entry            w_item;
    logic [WIDE_W-1:0] w_child;
    logic [WIDE_W-1:0] w_child1;
    logic [WIDE_W-1:0] w_n_wide;
    logic [ADDR_W-1:0] w_parent;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_full   = (CMP_W'(r_count) >= CMP_W'(r_cap))
                   || (r_count == CNT_W'(MAX_ENTRIES));
    assign w_item   = '{cost: i_item.item_cost, payload: i_item.item_payload};
    assign w_child  = {1'b0, r_pos, 1'b1};
    assign w_child1 = w_child + WIDE_W'(1);
    assign w_n_wide = WIDE_W'(r_n);
    assign w_parent = (r_pos - ADDR_W'(1)) >> 1;

    always_comb begin
        o_cmp_req.a = r_x;
        o_cmp_req.b = r_chosen;
        unique case (r_state)
            S_SU_CMP: begin
                o_cmp_req.a = i_ram_rdata;
                o_cmp_req.b = r_x;
            end
            S_SD_R: begin
                o_cmp_req.a = r_left;
                o_cmp_req.b = i_ram_rdata;
            end
            default: begin
                o_cmp_req.a = r_x;
                o_cmp_req.b = r_chosen;
            end
        endcase
    end

    always_comb begin
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_pos;
        o_ram_req.wdata = r_x;
        o_ram_req.raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.opcode == OP_LOAD) && !w_full) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_count[ADDR_W-1:0];
                    o_ram_req.wdata = w_item;
                end
            end
            S_SU_CHK: begin
                if (r_pos == '0) begin
                    o_ram_req.we = 1'b1;
                end else begin
                    o_ram_req.raddr = w_parent;
                end
            end
            S_SU_CMP: begin
                o_ram_req.we = 1'b1;
                if (i_cmp_rsp.a_gt_b) begin
                    o_ram_req.wdata = i_ram_rdata;
                end
            end
            S_BD_RD: o_ram_req.raddr = r_j;
            S_DL_RD: o_ram_req.raddr = r_n[ADDR_W-1:0];
            S_SD_CHK: begin
                if (w_child >= w_n_wide) begin
                    o_ram_req.we = 1'b1;
                end else begin
                    o_ram_req.raddr = w_child[ADDR_W-1:0];
                end
            end
            S_SD_L: o_ram_req.raddr = w_child1[ADDR_W-1:0];
            S_SD_DEC: begin
                o_ram_req.we = 1'b1;
                if (i_cmp_rsp.a_gt_b) begin
                    o_ram_req.wdata = r_chosen;
                end
            end
            default: o_ram_req.raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CAP_W'(CAP_RESET);
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= ST_OK;
                        r_build  <= 1'b0;
                        r_state  <= S_TOP_RD;
                        unique case (i_item.opcode)
                            OP_LOAD: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_INSERT: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_pos   <= r_count[ADDR_W-1:0];
                                    r_x     <= w_item;
                                    r_count <= r_count + CNT_W'(1);
                                    r_state <= S_SU_CHK;
                                end
                            end
                            OP_BUILD: begin
                                if (r_count >= CNT_W'(2)) begin
                                    r_build <= 1'b1;
                                    r_n     <= r_count;
                                    r_j     <= ADDR_W'((r_count - CNT_W'(2)) >> 1);
                                    r_state <= S_BD_RD;
                                end
                            end
                            OP_DELETE: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_count <= r_count - CNT_W'(1);
                                    r_n     <= r_count - CNT_W'(1);
                                    r_state <= S_DL_RD;
                                end
                            end
                            OP_PEEK: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end
                            end
                            default: r_status <= ST_OK;
                        endcase
                    end
                end
                S_SU_CHK: begin
                    r_state <= (r_pos == '0) ? S_TOP_RD : S_SU_CMP;
                end
                S_SU_CMP: begin
                    if (i_cmp_rsp.a_gt_b) begin
                        r_pos   <= w_parent;
                        r_state <= S_SU_CHK;
                    end else begin
                        r_state <= S_TOP_RD;
                    end
                end
                S_BD_RD: r_state <= S_BD_LAT;
                S_BD_LAT: begin
                    r_x     <= i_ram_rdata;
                    r_pos   <= r_j;
                    r_state <= S_SD_CHK;
                end
                S_DL_RD: r_state <= S_DL_LAT;
                S_DL_LAT: begin
                    r_x     <= i_ram_rdata;
                    r_pos   <= '0;
                    r_state <= S_SD_CHK;
                end
                S_SD_CHK: begin
                    r_state <= (w_child >= w_n_wide) ? S_SD_END : S_SD_L;
                end
                S_SD_L: begin
                    r_left <= i_ram_rdata;
                    if (w_child1 < w_n_wide) begin
                        r_state <= S_SD_R;
                    end else begin
                        r_chosen <= i_ram_rdata;
                        r_cidx   <= w_child[ADDR_W-1:0];
                        r_state  <= S_SD_DEC;
                    end
                end
                S_SD_R: begin
                    r_chosen <= i_cmp_rsp.lesser;
                    r_cidx   <= i_cmp_rsp.a_gt_b ? w_child1[ADDR_W-1:0]
                                                 : w_child[ADDR_W-1:0];
                    r_state  <= S_SD_DEC;
                end
                S_SD_DEC: begin
                    if (i_cmp_rsp.a_gt_b) begin
                        r_pos   <= r_cidx;
                        r_state <= S_SD_CHK;
                    end else begin
                        r_state <= S_SD_END;
                    end
                end
                S_SD_END: begin
                    if (r_build && (r_j != '0)) begin
                        r_j     <= r_j - ADDR_W'(1);
                        r_state <= S_BD_RD;
                    end else begin
                        r_state <= S_TOP_RD;
                    end
                end
                S_TOP_RD: r_state <= S_TOP_LAT;
                S_TOP_LAT: begin
                    r_result.status <= r_status;
                    r_result.count  <= r_count;
                    if (r_count == '0) begin
                        r_result.top_cost    <= '0;
                        r_result.top_payload <= '0;
                    end else begin
                        r_result.top_cost    <= i_ram_rdata.cost;
                        r_result.top_payload <= i_ram_rdata.payload;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== design/bmhpq_chk.sv =====
// ----------------------------------------------------------------------------
// bmhpq_chk
// Port-level checks of command, result strobe and reset behavior.
// ----------------------------------------------------------------------------
`include "binary_min_heap_priority_queue_top_defines.svh"

module bmhpq_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input bmhpq_pkg::t_out_item o_result
);
    import bmhpq_pkg::*;

    logic w_top_zero;

    assign w_top_zero = (o_result.count == '0) && (o_result.top_cost == '0)
                     && (o_result.top_payload == '0);

    `BMHPQ_ASSERT(a_cmd_goes_busy, start && !busy |=> busy)
    `BMHPQ_ASSERT(a_done_after_busy, o_done |-> !busy && $past(busy))
    `BMHPQ_ASSERT(a_count_bound, o_done |-> o_result.count <= CNT_W'(MAX_ENTRIES))
    `BMHPQ_ASSERT(a_empty_zero, o_done && (o_result.status == ST_EMPTY) |-> w_top_zero)
    `BMHPQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_done && !busy)

endmodule

bind binary_min_heap_priority_queue_top bmhpq_chk u_bmhpq_chk (.*);

// ===== sim/binary_min_heap_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_checker
// Watches the command, result and capacity channels of the heap queue.
// Keeps its own copy of the heap and the capacity register, works out the
// result of every accepted command and compares each result beat, field by
// field, against the oldest outcome still owed. Hands back a mismatch count
// and the number of outcomes still owed.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  bmhpq_pkg::t_in_item          i_item,
    input  logic                         i_done,
    input  bmhpq_pkg::t_out_item         i_result,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [bmhpq_pkg::CAP_W-1:0]  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import bmhpq_pkg::*;

    t_entry           slots [MAX_ENTRIES];
    int               held;
    logic [CAP_W-1:0] capacity;
    t_out_item        owed_results [$];
    int               fail_count;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("heap check: %s got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic void swap_slots(int a, int b);
        t_entry tmp;
        tmp      = slots[a];
        slots[a] = slots[b];
        slots[b] = tmp;
    endfunction

    function automatic void heap_sink(int pos, int n);
        int child;
        while (2 * pos + 1 < n) begin
            child = 2 * pos + 1;
            if (child + 1 < n && $signed(slots[child].cost) > $signed(slots[child + 1].cost))
                child++;
            if ($signed(slots[pos].cost) <= $signed(slots[child].cost))
                break;
            swap_slots(pos, child);
            pos = child;
        end
    endfunction

    function automatic void heap_rise(int pos);
        int up;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if ($signed(slots[up].cost) > $signed(slots[pos].cost))
                swap_slots(up, pos);
            else
                break;
            pos = up;
        end
    endfunction

    function automatic t_out_item heap_op_outcome(t_in_item cmd);
        t_out_item res;
        int        limit;
        limit      = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
        res.status = ST_OK;
        case (cmd.opcode)
            OP_LOAD, OP_INSERT: begin
                if (held >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    slots[held].cost    = cmd.item_cost;
                    slots[held].payload = cmd.item_payload;
                    if (cmd.opcode == OP_INSERT)
                        heap_rise(held);
                    held++;
                end
            end
            OP_BUILD: begin
                if (held >= 2)
                    for (int j = (held - 2) / 2; j >= 0; j--)
                        heap_sink(j, held);
            end
            OP_DELETE: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held--;
                    slots[0] = slots[held];
                    heap_sink(0, held);
                end
            end
            OP_PEEK: begin
                if (held == 0)
                    res.status = ST_EMPTY;
            end
            default: ;
        endcase
        if (held > 0) begin
            res.top_cost    = slots[0].cost;
            res.top_payload = slots[0].payload;
        end else begin
            res.top_cost    = '0;
            res.top_payload = '0;
        end
        res.count = held[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held     = 0;
            capacity = CAP_RESET[CAP_W-1:0];
            owed_results.delete();
        end else begin
            if (i_done) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with nothing owed, count", i_result.count, 0);
                end else begin
                    t_out_item want;
                    want = owed_results.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.top_cost !== want.top_cost)
                        report_mismatch("top_cost", i_result.top_cost, want.top_cost);
                    if (i_result.top_payload !== want.top_payload)
                        report_mismatch("top_payload", i_result.top_payload, want.top_payload);
                    if (i_result.count !== want.count)
                        report_mismatch("count", i_result.count, want.count);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            if (i_start && !i_busy)
                owed_results.push_back(heap_op_outcome(i_item));
        end
        o_pending <= owed_results.size();
    end

    initial begin
        fail_count = 0;
        held       = 0;
        capacity   = CAP_RESET[CAP_W-1:0];
    end

endmodule

// ===== sim/binary_min_heap_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top_test
// Drives the heap queue with a directed pass over empty, full, unordered,
// tie and spare-opcode cases, then with phases of random commands under a
// range of capacity settings (zero, one, small, nominal, saturating), with
// and without random gaps between commands. A checker alongside the block
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top_test;
    import bmhpq_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [31:0] COST_MIN = 32'h8000_0000;
    localparam logic [31:0] COST_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_item;
    logic             o_done;
    t_out_item        o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    int               fail_count;
    int               pending;
    int               issued;
    int               finished;

    binary_min_heap_priority_queue_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    binary_min_heap_priority_queue_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            finished <= 0;
        else if (o_done)
            finished <= finished + 1;
    end

    function automatic t_in_item cmd(logic [2:0] op, logic [31:0] cost, logic [31:0] pay);
        t_in_item it;
        it.opcode       = op;
        it.item_cost    = cost;
        it.item_payload = pay;
        return it;
    endfunction

    // start stays high across back-to-back beats; it is dropped by a gap or a drain
    task automatic issue(input t_in_item it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (finished != issued) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item random_cmd(bit grow);
        logic [2:0] op;
        int         r;
        int         c;
        r = $urandom_range(0, 99);
        if (grow)
            op = (r < 15) ? OP_LOAD : (r < 18) ? OP_BUILD : (r < 58) ? OP_INSERT :
                 (r < 78) ? OP_DELETE : (r < 92) ? OP_PEEK : OP_SPARE_LO;
        else
            op = (r < 5) ? OP_LOAD : (r < 8) ? OP_BUILD : (r < 28) ? OP_INSERT :
                 (r < 80) ? OP_DELETE : (r < 93) ? OP_PEEK : OP_SPARE_LO;
        if (op == OP_SPARE_LO)
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        // narrow keys force ties on the sift paths
        if ($urandom_range(0, 1)) begin
            c = $urandom;
        end else begin
            c = $urandom_range(0, 8);
            c = c - 4;
        end
        return cmd(op, c, $urandom);
    endfunction

    initial begin
        int cap_plan [10];
        bit quiet;
        int gap;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        issued      = 0;
        cap_plan    = '{1024, 3, 0, 1, 2047, 17, 2, 1024, 40, 1024};
        cap_plan[9] = $urandom_range(4, 64);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty heap cases
        issue(cmd(OP_PEEK,   '0, '0), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        issue(cmd(OP_BUILD,  '0, '0), 0);
        // raw loads, root is not the minimum until built
        issue(cmd(OP_LOAD, COST_MAX, ALL_ONES), 0);
        issue(cmd(OP_LOAD, COST_MIN, '0), 0);
        issue(cmd(OP_LOAD, ALL_ONES, 32'h5555_5555), 0);
        issue(cmd(OP_LOAD, '0, 32'hAAAA_AAAA), 0);
        issue(cmd(OP_PEEK, '0, '0), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        issue(cmd(OP_BUILD, '0, '0), 0);
        // equal keys must not swap
        issue(cmd(OP_INSERT, COST_MIN, 32'h0000_0001), 0);
        issue(cmd(OP_INSERT, '0, 32'h0000_0002), 0);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            issue(cmd(3'(op), COST_MAX, ALL_ONES), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        // capacity below the held count
        write_capacity(11'd2);
        issue(cmd(OP_INSERT, 32'd5, 32'd5), 0);
        issue(cmd(OP_LOAD, 32'd6, 32'd6), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        issue(cmd(OP_DELETE, '0, '0), 0);
        issue(cmd(OP_INSERT, 32'd7, 32'd7), 0);
        issue(cmd(OP_INSERT, 32'd8, 32'd8), 0);
        write_capacity(11'd0);
        issue(cmd(OP_INSERT, 32'd9, 32'd9), 0);
        write_capacity(11'd2047);
        issue(cmd(OP_INSERT, COST_MIN, ALL_ONES), 0);

        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(CAP_W'(cap_plan[ph]));
            quiet = (ph % 3 == 0);
            for (int k = 0; k < 60; k++) begin
                gap = quiet ? 0 : $urandom_range(0, 10);
                issue(random_cmd(k < 35), gap);
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bmhpq_pkg.sv
design/bmhpq_ram.sv
design/bmhpq_cmp.sv
design/bmhpq_ctrl.sv
design/binary_min_heap_priority_queue_top.sv
design/bmhpq_chk.sv
sim/binary_min_heap_priority_queue_checker.sv
sim/binary_min_heap_priority_queue_top_test.sv
